// ===== rtl/core/dual_port_vram_access_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual-port video RAM access engine
// Property wrappers with clock and an active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef DUAL_PORT_VRAM_ACCESS_ENGINE_CORE_MACROS_SVH
`define DUAL_PORT_VRAM_ACCESS_ENGINE_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DPVAE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define DPVAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dpvae_pkg.sv =====
// ----------------------------------------------------------------------------
// dpvae_pkg
// Shared constants, codes and helpers of the dual-port video RAM engine.
// ----------------------------------------------------------------------------
package dpvae_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int WORD_AW_DEF   = ADDR_BITS_DEF - 1;
    localparam int NUM_PORTS     = 2;
    localparam int PTR_W         = 16;
    localparam int BYTE_W        = 8;
    localparam int WORD_W        = 2 * BYTE_W;

    localparam logic [PTR_W-1:0]  ADDR_HI_MASK = 16'hfe00;
    localparam logic [PTR_W-1:0]  ADDR_LO_MASK = 16'h01fe;
    localparam logic [BYTE_W-1:0] NIB_HI_MASK  = 8'hf0;
    localparam logic [BYTE_W-1:0] NIB_LO_MASK  = 8'h0f;

    // request mode
    localparam logic [1:0] MODE_ADDR  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // operation in offset bits 2:0
    localparam logic [2:0] OP_PAIR_ODD  = 3'd1;
    localparam logic [2:0] OP_PAIR_EVEN = 3'd2;
    localparam logic [2:0] OP_ALT       = 3'd3;
    localparam logic [2:0] OP_HIGH      = 3'd5;
    localparam logic [2:0] OP_LOW       = 3'd6;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_vram_ctl;

    // when trans is set, zero nibbles of the new byte keep the stored nibble
    function automatic logic [BYTE_W-1:0] keep_nibbles(
        input logic [BYTE_W-1:0] nv,
        input logic [BYTE_W-1:0] old,
        input logic              trans
    );
        logic [BYTE_W-1:0] v;
        v = nv;
        if (trans) begin
            if ((nv & NIB_HI_MASK) == '0) v = v | (old & NIB_HI_MASK);
            if ((nv & NIB_LO_MASK) == '0) v = v | (old & NIB_LO_MASK);
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/dpvae_vram.sv =====
// ----------------------------------------------------------------------------
// dpvae_vram
// Word-wide video RAM (two bytes per row), registered read,
// with a row-per-cycle clearing pass after reset.
// ----------------------------------------------------------------------------
module dpvae_vram
    import dpvae_pkg::*;
#(
    parameter int WORD_AW = WORD_AW_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_vram_ctl          i_ctl,
    input  logic [WORD_AW-1:0] i_rd_addr,
    input  logic [WORD_AW-1:0] i_wr_addr,
    input  logic [WORD_W-1:0]  i_wr_data,
    output logic [WORD_W-1:0]  o_rd_data,
    output logic               o_busy
);

    localparam int DEPTH = 2 ** WORD_AW;

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rd_data;
    logic [WORD_AW-1:0] r_clr_addr;
    logic               r_clr_busy;

    logic               mem_we;
    logic [WORD_AW-1:0] mem_wa;
    logic [WORD_W-1:0]  mem_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign mem_we = r_clr_busy | i_ctl.wr_en;
    assign mem_wa = r_clr_busy ? r_clr_addr : i_wr_addr;
    assign mem_wd = r_clr_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// ===== rtl/core/dual_port_vram_access_engine_core.sv =====
// ----------------------------------------------------------------------------
// dual_port_vram_access_engine_core
// Two access ports into a shared byte video RAM: pointer set, read, write.
// ----------------------------------------------------------------------------
// Each request is handled in turn: the cycle it is accepted reads the addressed
// RAM row (two bytes), then ST_EXEC modifies that row, writes it back and
// loads the result register once the output is free, so no request is taken
// while one is in flight, set by the single read-then-write pass through the
// RAM port. A result waiting on m_axis_tready does not block acceptance of the
// next request, only its completion. After reset the RAM is cleared one row
// per cycle, during which no request is accepted.
module dual_port_vram_access_engine_core
    import dpvae_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [7:0]  s_axis_tuser,   // [1:0] mode, [2] port, [7:3] offset
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] read_byte, [23:8] pointer_after
    output logic        m_axis_tuser    // [0] op_known
);

    localparam int WORD_AW = ADDR_BITS - 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [ADDR_BITS-1:0] r_ptr    [NUM_PORTS];
    logic [BYTE_W-1:0]    r_lat_lo [NUM_PORTS];
    logic [BYTE_W-1:0]    r_lat_hi [NUM_PORTS];

    logic [1:0]           r_mode;
    logic                 r_port;
    logic [4:0]           r_off;
    logic [BYTE_W-1:0]    r_data;
    logic [ADDR_BITS-1:0] r_a;

    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_rd;
    logic [PTR_W-1:0]     r_out_ptr;
    logic                 r_out_known;

    logic [ADDR_BITS-1:0] n_ptr;
    logic [WORD_W-1:0]    n_word;
    logic [BYTE_W-1:0]    n_rd;
    logic                 n_known;
    logic                 n_wr;
    logic                 n_lat_lo_we;
    logic                 n_lat_hi_we;

    t_vram_ctl            vram_ctl;
    logic [WORD_W-1:0]    rd_word;
    logic                 vram_busy;

    logic                 s_accept;
    logic                 out_free;
    logic                 commit;
    logic                 in_port;
    logic [2:0]           op;
    logic                 trans;
    logic [ADDR_BITS-1:0] a_inc;
    logic [ADDR_BITS-1:0] a_alt;
    logic [PTR_W-1:0]     a16;
    logic [PTR_W-1:0]     set_lo;
    logic [PTR_W-1:0]     set_hi;
    logic [BYTE_W-1:0]    old_byte;

    assign in_port       = s_axis_tuser[2];
    assign s_axis_tready = (r_state == ST_IDLE) && !vram_busy;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign commit        = (r_state == ST_EXEC) && out_free;

    assign vram_ctl.rd_en = s_accept;
    assign vram_ctl.wr_en = commit && n_wr;

    dpvae_vram #(
        .WORD_AW (WORD_AW)
    ) u_vram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (vram_ctl),
        .i_rd_addr (r_ptr[in_port][ADDR_BITS-1:1]),
        .i_wr_addr (r_a[ADDR_BITS-1:1]),
        .i_wr_data (n_word),
        .o_rd_data (rd_word),
        .o_busy    (vram_busy)
    );

    assign op       = r_off[2:0];
    assign trans    = r_off[4] && r_port;
    assign a_inc    = r_a + ADDR_BITS'({r_off[3], 1'b0});
    assign a_alt    = (r_a[0] ? a_inc : r_a) ^ ADDR_BITS'(1);
    assign a16      = PTR_W'(r_a);
    assign set_lo   = (a16 & ADDR_HI_MASK) | (PTR_W'({r_data, 1'b0}) & ADDR_LO_MASK);
    assign set_hi   = (PTR_W'({r_data, 9'b0}) & ADDR_HI_MASK) | (a16 & ADDR_LO_MASK);
    assign old_byte = r_a[0] ? rd_word[WORD_W-1:BYTE_W] : rd_word[BYTE_W-1:0];

    always_comb begin
        n_ptr       = r_a;
        n_word      = rd_word;
        n_rd        = '0;
        n_known     = 1'b1;
        n_wr        = 1'b0;
        n_lat_lo_we = 1'b0;
        n_lat_hi_we = 1'b0;
        case (r_mode)
            MODE_ADDR: begin
                n_ptr = (r_off == '0) ? ADDR_BITS'(set_lo) : ADDR_BITS'(set_hi);
            end
            MODE_READ: begin
                case (op)
                    OP_ALT: begin
                        n_rd  = old_byte;
                        n_ptr = a_alt;
                    end
                    OP_HIGH: begin
                        n_rd  = rd_word[WORD_W-1:BYTE_W];
                        n_ptr = a_inc;
                    end
                    OP_LOW: begin
                        n_rd  = rd_word[BYTE_W-1:0];
                        n_ptr = a_inc;
                    end
                    default: begin
                        n_known = 1'b0;
                    end
                endcase
            end
            MODE_WRITE: begin
                case (op)
                    OP_PAIR_ODD: begin
                        n_word = {r_data, r_lat_lo[r_port]};
                        n_wr   = 1'b1;
                        n_ptr  = a_inc;
                    end
                    OP_PAIR_EVEN: begin
                        n_word = {r_lat_hi[r_port], r_data};
                        n_wr   = 1'b1;
                        n_ptr  = a_inc;
                    end
                    OP_ALT: begin
                        if (r_a[0]) begin
                            n_word[WORD_W-1:BYTE_W] = keep_nibbles(r_data, old_byte, trans);
                        end else begin
                            n_word[BYTE_W-1:0] = keep_nibbles(r_data, old_byte, trans);
                        end
                        n_wr  = 1'b1;
                        n_ptr = a_alt;
                    end
                    OP_HIGH: begin
                        n_word[WORD_W-1:BYTE_W] =
                            keep_nibbles(r_data, rd_word[WORD_W-1:BYTE_W], trans);
                        n_lat_hi_we = 1'b1;
                        n_wr        = 1'b1;
                        n_ptr       = a_inc;
                    end
                    OP_LOW: begin
                        n_word[BYTE_W-1:0] = keep_nibbles(r_data, rd_word[BYTE_W-1:0], trans);
                        n_lat_lo_we = 1'b1;
                        n_wr        = 1'b1;
                        n_ptr       = a_inc;
                    end
                    default: begin
                        n_known = 1'b0;
                    end
                endcase
            end
            default: begin
                n_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_ptr[i]    <= '0;
                r_lat_lo[i] <= '0;
                r_lat_hi[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid    <= 1'b1;
                r_ptr[r_port]  <= n_ptr;
                if (n_lat_lo_we) r_lat_lo[r_port] <= r_data;
                if (n_lat_hi_we) r_lat_hi[r_port] <= r_data;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode <= s_axis_tuser[1:0];
            r_port <= in_port;
            r_off  <= s_axis_tuser[7:3];
            r_data <= s_axis_tdata;
            r_a    <= r_ptr[in_port];
        end
        if (commit) begin
            r_out_rd    <= n_rd;
            r_out_ptr   <= PTR_W'(n_ptr);
            r_out_known <= n_known;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ptr, r_out_rd};
    assign m_axis_tuser  = r_out_known;

endmodule

// ===== rtl/core/dpvae_checker.sv =====
// ----------------------------------------------------------------------------
// dpvae_checker
// Port-level checks of the dual-port video RAM access engine.
// ----------------------------------------------------------------------------
`include "dual_port_vram_access_engine_core_macros.svh"

module dpvae_checker
    import dpvae_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic s_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    `DPVAE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `DPVAE_ASSERT_SAME(a_unknown_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[BYTE_W-1:0] == '0, "unknown request returned data")
    `DPVAE_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_acc, !s_axis_tready, "request accepted while one in flight")
    `DPVAE_ASSERT_SAME(a_latency, i_clk, i_rst_n, s_acc && (!m_axis_tvalid || m_axis_tready), ##2 m_axis_tvalid, "result late with free output")

endmodule

bind dual_port_vram_access_engine_core dpvae_checker u_dpvae_checker (.*);
